>>> rtl/sactl_pkg.sv
// Shared types and constants for the set-associative tag directory with LRU.
// No dependencies; imported by sactl_lru_upd and set_assoc_cache_tag_lru_unit.
package sactl_pkg;

   localparam int MAX_SETS   = 1024;
   localparam int MAX_WAYS   = 8;
   localparam int SET_W      = $clog2(MAX_SETS);
   localparam int WAY_W      = 3;
   localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int TAG_W      = 30;
   localparam int AGE_W      = 3;
   localparam int ADDR_W     = 32;
   localparam int CNT_W      = 32;
   localparam int IB_W       = 4;
   localparam int OB_W       = 3;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   // reset values and upper limits of the configuration registers
   localparam logic [IB_W-1:0]       IB_RESET   = 4'd10;
   localparam logic [OB_W-1:0]       OB_RESET   = 3'd2;
   localparam logic [WAYS_CNT_W-1:0] WAYS_RESET = 4'd1;
   localparam logic [IB_W-1:0]       IB_MAX     = IB_W'(SET_W);
   localparam logic [WAYS_CNT_W-1:0] WAYS_MAX   = WAYS_CNT_W'(MAX_WAYS);

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } way_entry_type;

   typedef way_entry_type [MAX_WAYS-1:0] set_row_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      set_row_type      row;
   } lru_upd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

>>> rtl/sactl_lru_upd.sv
// Tag compare, victim choice and LRU age update for one directory row.
// Depends on sactl_pkg.
module sactl_lru_upd import sactl_pkg::*; (
   input  set_row_type            row,
   input  logic [TAG_W-1:0]       tag,
   input  logic [WAYS_CNT_W-1:0]  ways_eff,
   output lru_upd_type            upd
);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] free_vec;
   logic [WAY_W-1:0]    hit_sel;
   logic [WAY_W-1:0]    free_sel;
   logic [WAY_W-1:0]    best_sel;
   logic [AGE_W-1:0]    best_age;
   logic [WAY_W-1:0]    sel;
   logic [AGE_W-1:0]    ref_age;
   logic [AGE_W-1:0]    mru_age;
   logic                hit;
   logic                found;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]   = (WAYS_CNT_W'(w) < ways_eff);
         hit_vec[w]  = in_use[w] && row[w].valid && (row[w].tag == tag);
         free_vec[w] = in_use[w] && !row[w].valid;
      end
      hit   = |hit_vec;
      found = |free_vec;

      // lowest numbered way wins in both searches
      hit_sel  = '0;
      free_sel = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_sel = WAY_W'(w);
         end
         if (free_vec[w]) begin
            free_sel = WAY_W'(w);
         end
      end

      // oldest way, lowest numbered on a tie
      best_sel = '0;
      best_age = row[0].age;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && (row[w].age < best_age)) begin
            best_sel = WAY_W'(w);
            best_age = row[w].age;
         end
      end

      if (hit) begin
         sel     = hit_sel;
         ref_age = row[hit_sel].age;
      end else if (found) begin
         sel     = free_sel;
         ref_age = '0;
      end else begin
         sel     = best_sel;
         ref_age = best_age;
      end

      mru_age = AGE_W'(ways_eff - WAYS_CNT_W'(1));

      upd.hit = hit;
      upd.way = sel;
      upd.row = row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w]) begin
            if (WAY_W'(w) == sel) begin
               upd.row[w].age = mru_age;
               if (!hit) begin
                  upd.row[w].valid = 1'b1;
                  upd.row[w].tag   = tag;
               end
            end else if (row[w].age > ref_age) begin
               upd.row[w].age = row[w].age - AGE_W'(1);
            end
         end
      end
   end

endmodule

>>> rtl/set_assoc_cache_tag_lru_unit.sv
// A word accepted is read from the directory into the row register, then compared
// and written into the result register, held back while the previous result word
// still waits for the receiver. A new word is taken only once the previous one is
// written back, set by the read-modify-write of a set row in the directory memory
// (read, then compare and write back). Reset: synchronous; a clearing pass
// then writes all 1024 rows to zero, one row a cycle, while no word is accepted.
// Depends on sactl_pkg and sactl_lru_upd.
module set_assoc_cache_tag_lru_unit import sactl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // lookup requests
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_W-1:0]     req_address,
   // lookup results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [WAY_W-1:0]      rsp_way,
   output logic [SET_W-1:0]      rsp_set_index,
   output logic [TAG_W-1:0]      rsp_tag_value,
   output logic [CNT_W-1:0]      rsp_access_count,
   output logic [CNT_W-1:0]      rsp_hit_count,
   output logic [CNT_W-1:0]      rsp_miss_count,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Directory: one row per set, each row holding valid, tag and age of all ways.
   set_row_type dir_mem [MAX_SETS];

   state_type state_ff, state_in;

   logic [IB_W-1:0]       index_bits_ff;
   logic [OB_W-1:0]       offset_bits_ff;
   logic [WAYS_CNT_W-1:0] ways_in_use_ff;

   logic [SET_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   set_row_type      rd_row_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [WAY_W-1:0] rsp_way_ff;
   logic [SET_W-1:0] rsp_set_ff;
   logic [TAG_W-1:0] rsp_tag_ff;
   logic [CNT_W-1:0] lookups_ff, hits_ff, misses_ff;

   // effective configuration
   logic [IB_W-1:0]       ib_eff;
   logic [WAYS_CNT_W-1:0] ways_eff;
   logic [SHIFT_W-1:0]    shift;
   logic [SET_W-1:0]      set_mask;
   logic [SET_W-1:0]      req_set;
   logic [TAG_W-1:0]      req_tag;
   logic [ADDR_W-1:0]     addr_off;
   logic [ADDR_W-1:0]     addr_tag;

   // control from the sequencer
   logic             accept;
   logic             out_free;
   logic             commit;
   logic             rd_en;
   logic             wr_en;
   logic [SET_W-1:0] wr_addr;
   set_row_type      wr_row;

   lru_upd_type upd;

   // ---------------------------------------------------------------------
   // Configuration registers; writes beyond the list are dropped.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff  <= IB_RESET;
         offset_bits_ff <= OB_RESET;
         ways_in_use_ff <= WAYS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INDEX_BITS:  index_bits_ff  <= csr_wdata[IB_W-1:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata[OB_W-1:0];
            CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wdata[WAYS_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the index width at the directory depth, clamp the ways to 1..MAX_WAYS.
   always_comb begin
      ib_eff = (index_bits_ff > IB_MAX) ? IB_MAX : index_bits_ff;
      if (ways_in_use_ff == '0) begin
         ways_eff = WAYS_CNT_W'(1);
      end else if (ways_in_use_ff > WAYS_MAX) begin
         ways_eff = WAYS_MAX;
      end else begin
         ways_eff = ways_in_use_ff;
      end
   end

   // Split the address: offset below, set index next, tag above.
   always_comb begin
      shift    = SHIFT_W'(ib_eff) + SHIFT_W'(offset_bits_ff);
      set_mask = ~({SET_W{1'b1}} << ib_eff);
      addr_off = req_address >> offset_bits_ff;
      addr_tag = req_address >> shift;
      req_set  = addr_off[SET_W-1:0] & set_mask;
      req_tag  = addr_tag[TAG_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Sequencer: clear pass, then read a row on accept, write it back once the result is free.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      req_ready    = 1'b0;
      commit       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = set_ff;
      wr_row       = upd.row;
      out_free     = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clear_cnt_ff;
            wr_row       = '0;
            clear_cnt_in = clear_cnt_ff + SET_W'(1);
            if (clear_cnt_ff == {SET_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // hold the read row until the result register is free
            if (out_free) begin
               commit   = 1'b1;
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;
   assign rd_en  = accept;

   // Latch the split address for the write-back cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
   end

   // ---------------------------------------------------------------------
   // Directory memory: one write port, one registered read port.
   // The write of one lookup lands before the next read, so no forwarding.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dir_mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= dir_mem[req_set];
      end
   end

   sactl_lru_upd u_lru_upd (
      .row      (rd_row_ff),
      .tag      (tag_ff),
      .ways_eff (ways_eff),
      .upd      (upd)
   );

   // ---------------------------------------------------------------------
   // Running counts and result register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         lookups_ff <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
      end else if (commit) begin
         lookups_ff <= lookups_ff + CNT_W'(1);
         if (upd.hit) begin
            hits_ff <= hits_ff + CNT_W'(1);
         end else begin
            misses_ff <= misses_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff <= upd.hit;
         rsp_way_ff <= upd.way;
         rsp_set_ff <= set_ff;
         rsp_tag_ff <= tag_ff;
      end
   end

   // counters already hold this word's contribution once it is shown
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way          = rsp_way_ff;
   assign rsp_set_index    = rsp_set_ff;
   assign rsp_tag_value    = rsp_tag_ff;
   assign rsp_access_count = lookups_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_miss_count   = misses_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted word did not move to lookup");

   a_counts_agree: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(hits_ff + misses_ff) == lookups_ff)
      else $error("hit and miss counts do not add up to lookups");

   a_way_in_range: assert property (@(posedge clock) disable iff (reset)
      commit |-> (WAYS_CNT_W'(upd.way) < ways_eff))
      else $error("selected way outside the ways in use");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result word dropped");

   a_commit_one_per_accept: assert property (@(posedge clock) disable iff (reset)
      commit |-> $past(state_ff == ST_IDLE || state_ff == ST_LOOKUP))
      else $error("write-back without a preceding read");

endmodule

>>> dv/sactl_lookup_checker.sv
// Scoreboard for the set-associative tag directory: mirrors the directory,
// predicts each lookup result and compares it with the result channel.
// Depends on sactl_pkg.
`timescale 1ns / 100ps

module sactl_lookup_checker import sactl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_hit,
   input  logic [WAY_W-1:0]      rsp_way,
   input  logic [SET_W-1:0]      rsp_set_index,
   input  logic [TAG_W-1:0]      rsp_tag_value,
   input  logic [CNT_W-1:0]      rsp_access_count,
   input  logic [CNT_W-1:0]      rsp_hit_count,
   input  logic [CNT_W-1:0]      rsp_miss_count,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           lookups_in_flight
);

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic [SET_W-1:0] set_index;
      logic [TAG_W-1:0] tag_value;
      logic [CNT_W-1:0] access_count;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] miss_count;
   } lookup_result_type;

   localparam int ENTRIES = MAX_SETS * MAX_WAYS;

   // directory mirror, one entry per (set, way)
   logic             dir_valid [ENTRIES];
   logic [TAG_W-1:0] dir_tag   [ENTRIES];
   logic [AGE_W-1:0] dir_age   [ENTRIES];
   logic [CNT_W-1:0] lookups, hits, misses;

   logic [IB_W-1:0]       cfg_index_bits;
   logic [OB_W-1:0]       cfg_offset_bits;
   logic [WAYS_CNT_W-1:0] cfg_ways;

   lookup_result_type expected_lookups [$];
   int unsigned       failures = 0;

   // Walk one address through the mirror and return the result it must give.
   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] address);
      int unsigned       ib, ob, nw, set_no, base, sel, ref_age, best;
      logic [TAG_W-1:0]  tag;
      bit                hit, found;
      lookup_result_type r;
      ib = cfg_index_bits;
      while (ib > 0 && (1 << ib) > MAX_SETS)
         ib--;
      ob = cfg_offset_bits;
      nw = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);
      set_no = (address >> ob) & ((32'd1 << ib) - 32'd1);
      tag = TAG_W'(address >> (ib + ob));
      base = set_no * MAX_WAYS;
      hit = 1'b0;
      found = 1'b0;
      sel = 0;
      ref_age = 0;
      for (int w = 0; w < nw; w++) begin
         if (!hit && dir_valid[base + w] && dir_tag[base + w] == tag) begin
            hit = 1'b1;
            sel = w;
         end
      end
      lookups++;
      if (hit) begin
         hits++;
         ref_age = dir_age[base + sel];
      end else begin
         misses++;
         for (int w = 0; w < nw; w++) begin
            if (!found && !dir_valid[base + w]) begin
               found = 1'b1;
               sel = w;
            end
         end
         if (!found) begin
            // oldest way, lowest number on a tie; age zero need not exist
            best = 0;
            for (int w = 1; w < nw; w++)
               if (dir_age[base + w] < dir_age[base + best])
                  best = w;
            sel = best;
            ref_age = dir_age[base + sel];
         end
         dir_tag[base + sel] = tag;
         dir_valid[base + sel] = 1'b1;
      end
      for (int w = 0; w < nw; w++)
         if (w != sel && dir_age[base + w] > ref_age)
            dir_age[base + w] = dir_age[base + w] - 1'b1;
      dir_age[base + sel] = AGE_W'(nw - 1);
      r.hit = hit;
      r.way = WAY_W'(sel);
      r.set_index = SET_W'(set_no);
      r.tag_value = tag;
      r.access_count = lookups;
      r.hit_count = hits;
      r.miss_count = misses;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_tag[i] = '0;
            dir_age[i] = '0;
         end
         cfg_index_bits = IB_RESET;
         cfg_offset_bits = OB_RESET;
         cfg_ways = WAYS_RESET;
         lookups = '0;
         hits = '0;
         misses = '0;
         expected_lookups.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INDEX_BITS:  cfg_index_bits = csr_wdata[IB_W-1:0];
               CSR_OFFSET_BITS: cfg_offset_bits = csr_wdata[OB_W-1:0];
               CSR_WAYS_IN_USE: cfg_ways = csr_wdata[WAYS_CNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               $display("%0t: result word with none expected, set %h tag %h",
                        $time, rsp_set_index, rsp_tag_value);
               failures++;
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", want.hit, rsp_hit);
               check_field("way", want.way, rsp_way);
               check_field("set_index", want.set_index, rsp_set_index);
               check_field("tag_value", want.tag_value, rsp_tag_value);
               check_field("access_count", want.access_count, rsp_access_count);
               check_field("hit_count", want.hit_count, rsp_hit_count);
               check_field("miss_count", want.miss_count, rsp_miss_count);
            end
         end
         if (req_valid && req_ready)
            expected_lookups.push_back(predict_lookup(req_address));
      end
      lookups_in_flight <= expected_lookups.size();
      mismatch_count <= failures;
   end

endmodule

>>> dv/set_assoc_cache_tag_lru_unit_tb.sv
// Testbench top for the set-associative tag directory: drives lookup words and
// register writes, throttles both channels, and gives the verdict.
// Depends on sactl_pkg, set_assoc_cache_tag_lru_unit and sactl_lookup_checker.
`timescale 1ns / 100ps

module set_assoc_cache_tag_lru_unit_tb;
   import sactl_pkg::*;

   // index 3 is not a register; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned SEGMENT_WORDS = 75;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_hit;
   logic [WAY_W-1:0]      rsp_way;
   logic [SET_W-1:0]      rsp_set_index;
   logic [TAG_W-1:0]      rsp_tag_value;
   logic [CNT_W-1:0]      rsp_access_count;
   logic [CNT_W-1:0]      rsp_hit_count;
   logic [CNT_W-1:0]      rsp_miss_count;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned lookups_in_flight;

   // idle odds, in percent, for the sender and the receiver
   int unsigned req_idle_pct = 21;
   int unsigned rsp_idle_pct = 84;
   int unsigned results_taken = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   set_assoc_cache_tag_lru_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_set_index    (rsp_set_index),
      .rsp_tag_value    (rsp_tag_value),
      .rsp_access_count (rsp_access_count),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sactl_lookup_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_way           (rsp_way),
      .rsp_set_index     (rsp_set_index),
      .rsp_tag_value     (rsp_tag_value),
      .rsp_access_count  (rsp_access_count),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_miss_count    (rsp_miss_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .lookups_in_flight (lookups_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result word ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("set_assoc_cache_tag_lru_unit verification failed");
         $finish;
      end
   end

   // Receiver: take result words at the current idle odds. After the 41st
   // and the 501st word, hold off for a long stretch so that the block backs
   // up and has to drop req_ready while the sender keeps offering.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         results_taken <= results_taken + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready && (results_taken == 40 || results_taken == 500)) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one lookup word, with random idle cycles ahead of it, and hold it
   // until the block takes it. Leaves req_valid high; the drain or an idle draw in
   // the next call lowers it.
   task automatic send_lookup(input logic [ADDR_W-1:0] address);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_address <= address;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stop offering and wait until every predicted result word has come back.
   // The first edge lets the checker's count catch up with the last word.
   task automatic drain_lookups();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lookups_in_flight != 0)
         @(posedge clock);
   endtask

   // Write all three registers and the spare index, back to back; only called
   // with the block drained.
   task automatic write_config(input logic [3:0] index_bits, input logic [3:0] offset_bits,
                               input logic [3:0] ways);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_INDEX_BITS;
      csr_wdata <= index_bits;
      @(posedge clock);
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= offset_bits;
      @(posedge clock);
      csr_index <= CSR_WAYS_IN_USE;
      csr_wdata <= ways;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0]  seg_ib, seg_ob, seg_ways;
      int unsigned ib_eff, ob_eff, nw_eff, pool_size, seg;
      logic [31:0] tag_pool [10];
      logic [31:0] set_pool [4];
      logic [31:0] set_mask, address;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, ten index bits and a single way. Cold miss,
      // hit, all-ones address in the top set, then a conflicting tag evicts.
      send_lookup(32'h0000_0000);
      send_lookup(32'h0000_0000);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h0000_1000);
      send_lookup(32'h0000_0000);

      // One set, no offset: the tag is wider than 30 bits, so addresses
      // differing only in the top two bits alias. Fill four ways, then evict
      // the least recent.
      drain_lookups();
      write_config(4'd0, 4'd0, 4'd4);
      send_lookup(32'h0000_0000);
      send_lookup(32'hC000_0000);
      send_lookup(32'h0000_0001);
      send_lookup(32'h0000_0002);
      send_lookup(32'h0000_0003);
      send_lookup(32'h0000_0001);
      send_lookup(32'h0000_0005);

      // Shrink to two ways: the hidden ways are not searched, and no way in
      // use has age zero, so the lowest age loses.
      drain_lookups();
      write_config(4'd0, 4'd0, 4'd2);
      send_lookup(32'h0000_0002);
      send_lookup(32'h0000_0100);

      // Index width past the set count, widest offset, too many ways.
      drain_lookups();
      write_config(4'd15, 4'd7, 4'd15);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h0000_0000);
      send_lookup(32'h8000_0000);
      send_lookup(32'h7FFF_FFFF);
      send_lookup(32'hFFFF_FFFF);

      // Zero ways behaves as one.
      drain_lookups();
      write_config(4'd1, 4'd1, 4'd0);
      send_lookup(32'h0000_0000);
      send_lookup(32'h0000_0002);
      send_lookup(32'h0000_0000);

      // Random part: three idling modes, four settings each. Most words reuse
      // a small pool of tags and sets so that hits, evictions and ageing are
      // exercised; the rest are raw addresses.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 21;
               rsp_idle_pct <= 84;
            end
            1: begin
               req_idle_pct = 84;
               rsp_idle_pct <= 21;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            seg = mode * 4 + k;
            case (seg)
               0: begin seg_ib = 4'd0;  seg_ob = 4'd0;  seg_ways = 4'd8;  end
               1: begin seg_ib = 4'd15; seg_ob = 4'd7;  seg_ways = 4'd15; end
               2: begin seg_ib = 4'd10; seg_ob = 4'd2;  seg_ways = 4'd1;  end
               3: begin seg_ib = 4'd1;  seg_ob = 4'd9;  seg_ways = 4'd0;  end
               default: begin
                  seg_ib = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(3));
                  seg_ob = 4'($urandom_range(15));
                  seg_ways = 4'($urandom_range(15));
               end
            endcase
            drain_lookups();
            write_config(seg_ib, seg_ob, seg_ways);

            ib_eff = (seg_ib > SET_W) ? SET_W : seg_ib;
            ob_eff = seg_ob & 4'd7;
            nw_eff = (seg_ways == 0) ? 1 : ((seg_ways > MAX_WAYS) ? MAX_WAYS : seg_ways);
            pool_size = nw_eff + 2;
            set_mask = (32'd1 << ib_eff) - 32'd1;
            foreach (tag_pool[i])
               tag_pool[i] = $urandom;
            foreach (set_pool[i])
               set_pool[i] = $urandom & set_mask;

            repeat (SEGMENT_WORDS) begin
               if ($urandom_range(99) < 80) begin
                  address = (tag_pool[$urandom_range(pool_size - 1)] << (ib_eff + ob_eff))
                          | (set_pool[$urandom_range(3)] << ob_eff)
                          | ($urandom & ((32'd1 << ob_eff) - 32'd1));
               end else begin
                  address = $urandom;
               end
               send_lookup(address);
            end
         end
      end

      drain_lookups();
      // let any stray word show up before the verdict
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("set_assoc_cache_tag_lru_unit verification clean");
      else
         $display("set_assoc_cache_tag_lru_unit verification failed");
      $finish;
   end

endmodule

>>> set_assoc_cache_tag_lru_unit.f
rtl/sactl_pkg.sv
rtl/sactl_lru_upd.sv
rtl/set_assoc_cache_tag_lru_unit.sv
dv/sactl_lookup_checker.sv
dv/set_assoc_cache_tag_lru_unit_tb.sv
